// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the timestamp text core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true outside reset.
`define CHK_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/uts_pkg.sv =====
// Shared types, constants and reciprocal divisors for the timestamp text core.
package uts_pkg;

    localparam int SecondsW = 38;
    localparam logic [SecondsW-1:0] MaxSeconds = 38'd253402300799;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW = $clog2(QueueDepth);
    localparam int QueueCntW = $clog2(QueueDepth + 1);

    localparam int NumDigits = 14;
    localparam int NumLanes = 7;
    localparam int TextLen = 20;
    localparam logic [4:0] LastPos = 5'(TextLen - 1);

    localparam logic [9:0] DayDivisor = 10'd675;
    localparam logic [19:0] EpochDays = 20'd719468;
    localparam logic [17:0] DaysPerEra = 18'd146097;
    localparam logic [11:0] SecPerHour = 12'd3600;
    localparam logic [5:0] SecPerMin = 6'd60;
    localparam logic [8:0] DaysPerYear = 9'd365;
    localparam logic [8:0] YearsPerEra = 9'd400;
    localparam logic [17:0] CentDays1 = 18'd36524;
    localparam logic [17:0] CentDays2 = 18'd73048;
    localparam logic [17:0] CentDays3 = 18'd109572;

    localparam int DayShift = 41;
    localparam logic [31:0] DayRecip = 32'(((64'd1 << DayShift) + 64'd674) / 64'd675);
    localparam int HourShift = 29;
    localparam logic [17:0] HourRecip = 18'(((64'd1 << HourShift) + 64'd3599) / 64'd3600);
    localparam int MinShift = 18;
    localparam logic [12:0] MinRecip = 13'(((64'd1 << MinShift) + 64'd59) / 64'd60);
    localparam int EraShift = 40;
    localparam logic [22:0] EraRecip = 23'(((64'd1 << EraShift) + 64'd146096) / 64'd146097);
    localparam int QuadShift = 29;
    localparam logic [18:0] QuadRecip = 19'(((64'd1 << QuadShift) + 64'd1459) / 64'd1460);
    localparam int YearShift = 27;
    localparam logic [18:0] YearRecip = 19'(((64'd1 << YearShift) + 64'd364) / 64'd365);
    localparam int MonthShift = 19;
    localparam logic [11:0] MonthRecip = 12'(((64'd1 << MonthShift) + 64'd152) / 64'd153);
    localparam int HundShift = 21;
    localparam logic [14:0] HundRecip = 15'(((64'd1 << HundShift) + 64'd99) / 64'd100);
    localparam int TenShift = 11;
    localparam logic [7:0] TenRecip = 8'(((64'd1 << TenShift) + 64'd9) / 64'd10);

    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharDash = 8'h2D;
    localparam logic [7:0] CharT = 8'h54;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharZ = 8'h5A;

    typedef struct packed {
        logic [SecondsW-1:0] secs;
        logic                clamped;
    } t_item;

    typedef struct packed {
        logic [NumDigits-1:0][3:0] digit;
        logic                      clamped;
    } t_line;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAYQ,
        S_DAYR,
        S_DIVQ,
        S_DIVR,
        S_SUBQ,
        S_SUBR,
        S_YOEQ,
        S_DOY,
        S_MPQ,
        S_DATE,
        S_YEARQ,
        S_YEARR,
        S_TENS,
        S_ONES,
        S_DONE
    } t_conv_state;

    function automatic logic [8:0] month_start(logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/core/uts_front.sv =====
// Input stage: takes items, clamps out-of-range times and feeds the queue.
module uts_front import uts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SecondsW-1:0] i_unix_seconds,
    output logic                o_stall,
    input  logic                i_full,
    output logic                o_push,
    output t_item               o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;
    logic  w_over;

    assign o_stall  = r_valid && i_full;
    assign o_push   = r_valid && !i_full;
    assign o_item   = r_item;
    assign w_accept = i_valid && !o_stall;
    assign w_over   = i_unix_seconds > MaxSeconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.secs    <= w_over ? MaxSeconds : i_unix_seconds;
            r_item.clamped <= w_over;
        end
    end

endmodule

// ===== rtl/core/uts_fifo.sv =====
// Short queue of clamped items between the input stage and the converter.
`include "assert_macros.svh"
module uts_fifo import uts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr;
    logic [QueuePtrW-1:0] r_rd;
    logic [QueueCntW-1:0] r_count;

    assign o_full  = r_count == QueueCntW'(QueueDepth);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `CHK_NEVER(a_no_overflow, i_push && !i_pop && o_full, "queue written while full")
    `CHK_NEVER(a_no_underflow, i_pop && !o_valid, "queue read while empty")

endmodule

// ===== rtl/core/uts_conv.sv =====
// Sequenced converter from seconds to the fourteen decimal digits of the text.
`include "assert_macros.svh"
module uts_conv import uts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_line o_line
);

    t_conv_state r_state;
    t_conv_state n_state;

    logic [SecondsW-1:0] r_t;
    logic                r_clamp;
    logic [21:0]         r_days;
    logic [16:0]         r_sod;
    logic [21:0]         r_z;
    logic [4:0]          r_era;
    logic [4:0]          r_hour;
    logic [17:0]         r_doe;
    logic [11:0]         r_remh;
    logic [6:0]          r_q1460;
    logic [5:0]          r_min;
    logic [17:0]         r_num;
    logic [5:0]          r_sec;
    logic [8:0]          r_yoe;
    logic [8:0]          r_doy;
    logic [13:0]         r_ybase;
    logic [3:0]          r_mp;
    logic [4:0]          r_dom;
    logic [3:0]          r_mo;
    logic [13:0]         r_year;
    logic [6:0]          r_yhi;
    logic [6:0]          r_ylo;
    logic [3:0]          r_tens [NumLanes];
    t_line               r_line;

    logic [62:0] w_day_prod;
    logic [30:0] w_day_back;
    logic [44:0] w_era_prod;
    logic [34:0] w_hour_prod;
    logic [36:0] w_quad_prod;
    logic [24:0] w_min_prod;
    logic [1:0]  w_cent_cnt;
    logic [36:0] w_yoe_prod;
    logic [1:0]  w_yoe_cent;
    logic [17:0] w_yoe_days;
    logic [10:0] w_mp_arg;
    logic [22:0] w_mp_prod;
    logic        w_jan_feb;
    logic [28:0] w_hund_prod;
    logic [6:0]  w_val [NumLanes];
    logic [14:0] w_ten_prod [NumLanes];

    assign w_day_prod  = 63'(r_t[SecondsW-1:7]) * 63'(DayRecip);
    assign w_day_back  = 31'(r_days) * 31'(DayDivisor);
    assign w_era_prod  = 45'(r_z) * 45'(EraRecip);
    assign w_hour_prod = 35'(r_sod) * 35'(HourRecip);
    assign w_quad_prod = 37'(r_doe) * 37'(QuadRecip);
    assign w_min_prod  = 25'(r_remh) * 25'(MinRecip);
    assign w_cent_cnt  = 2'(r_doe >= CentDays1) + 2'(r_doe >= CentDays2)
                       + 2'(r_doe >= CentDays3);
    assign w_yoe_prod  = 37'(r_num) * 37'(YearRecip);
    assign w_yoe_cent  = 2'(r_yoe >= 9'd100) + 2'(r_yoe >= 9'd200) + 2'(r_yoe >= 9'd300);
    assign w_yoe_days  = 18'(r_yoe) * 18'(DaysPerYear) + 18'(r_yoe[8:2]) - 18'(w_yoe_cent);
    assign w_mp_arg    = 11'(r_doy) * 11'd5 + 11'd2;
    assign w_mp_prod   = 23'(w_mp_arg) * 23'(MonthRecip);
    assign w_jan_feb   = r_mp >= 4'd10;
    assign w_hund_prod = 29'(r_year) * 29'(HundRecip);

    always_comb begin
        w_val[0] = r_yhi;
        w_val[1] = r_ylo;
        w_val[2] = 7'(r_mo);
        w_val[3] = 7'(r_dom);
        w_val[4] = 7'(r_hour);
        w_val[5] = 7'(r_min);
        w_val[6] = 7'(r_sec);
        for (int i = 0; i < NumLanes; i++) begin
            w_ten_prod[i] = 15'(w_val[i]) * 15'(TenRecip);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DAYQ;
                end
            end
            S_DAYQ:  n_state = S_DAYR;
            S_DAYR:  n_state = S_DIVQ;
            S_DIVQ:  n_state = S_DIVR;
            S_DIVR:  n_state = S_SUBQ;
            S_SUBQ:  n_state = S_SUBR;
            S_SUBR:  n_state = S_YOEQ;
            S_YOEQ:  n_state = S_DOY;
            S_DOY:   n_state = S_MPQ;
            S_MPQ:   n_state = S_DATE;
            S_DATE:  n_state = S_YEARQ;
            S_YEARQ: n_state = S_YEARR;
            S_YEARR: n_state = S_TENS;
            S_TENS:  n_state = S_ONES;
            S_ONES:  n_state = S_DONE;
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE:  o_pop = i_valid;
            S_DONE:  o_valid = 1'b1;
            default: begin
                o_pop   = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_line = r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_t     <= i_item.secs;
                    r_clamp <= i_item.clamped;
                end
            end
            S_DAYQ: begin
                r_days <= 22'(w_day_prod >> DayShift);
            end
            S_DAYR: begin
                r_sod <= {10'(r_t[SecondsW-1:7] - w_day_back), r_t[6:0]};
                r_z   <= r_days + 22'(EpochDays);
            end
            S_DIVQ: begin
                r_era  <= 5'(w_era_prod >> EraShift);
                r_hour <= 5'(w_hour_prod >> HourShift);
            end
            S_DIVR: begin
                r_doe  <= 18'(r_z - 22'(r_era) * 22'(DaysPerEra));
                r_remh <= 12'(r_sod - 17'(r_hour) * 17'(SecPerHour));
            end
            S_SUBQ: begin
                r_q1460 <= 7'(w_quad_prod >> QuadShift);
                r_min   <= 6'(w_min_prod >> MinShift);
            end
            S_SUBR: begin
                r_num <= r_doe - 18'(r_q1460) + 18'(w_cent_cnt);
                r_sec <= 6'(r_remh - 12'(r_min) * 12'(SecPerMin));
            end
            S_YOEQ: begin
                r_yoe <= 9'(w_yoe_prod >> YearShift);
            end
            S_DOY: begin
                r_doy   <= 9'(r_doe - w_yoe_days);
                r_ybase <= 14'(r_yoe) + 14'(r_era) * 14'(YearsPerEra);
            end
            S_MPQ: begin
                r_mp <= 4'(w_mp_prod >> MonthShift);
            end
            S_DATE: begin
                r_dom  <= 5'(r_doy - month_start(r_mp) + 9'd1);
                r_mo   <= w_jan_feb ? r_mp - 4'd9 : r_mp + 4'd3;
                r_year <= r_ybase + 14'(w_jan_feb);
            end
            S_YEARQ: begin
                r_yhi <= 7'(w_hund_prod >> HundShift);
            end
            S_YEARR: begin
                r_ylo <= 7'(r_year - 14'(r_yhi) * 14'd100);
            end
            S_TENS: begin
                for (int i = 0; i < NumLanes; i++) begin
                    r_tens[i] <= 4'(w_ten_prod[i] >> TenShift);
                end
            end
            S_ONES: begin
                for (int i = 0; i < NumLanes; i++) begin
                    r_line.digit[2*i]   <= r_tens[i];
                    r_line.digit[2*i+1] <= 4'(w_val[i] - 7'(r_tens[i]) * 7'd10);
                end
                r_line.clamped <= r_clamp;
            end
            default: begin
            end
        endcase
    end

    `CHK_NEXT(a_line_held, o_valid && !i_ready, o_valid && $stable(o_line),
              "finished line changed before the emitter took it")
    `CHK_IMPL(a_pop_idle, o_pop, !o_valid && i_valid, "queue popped while a line is pending")

endmodule

// ===== rtl/core/uts_emit.sv =====
// Output stage: holds one converted line and sends its twenty characters in order.
`include "assert_macros.svh"
module uts_emit import uts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_line_valid,
    input  t_line       i_line,
    output logic        o_line_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic [4:0]  o_char_position,
    output logic        o_last_char,
    output logic        o_range_clamped
);

    logic       r_busy;
    logic [4:0] r_pos;
    t_line      r_line;
    logic       w_take;
    logic       w_at_last;
    logic       w_load;

    function automatic logic [7:0] digit_char(logic [3:0] d);
        return CharZero + 8'(d);
    endfunction

    function automatic logic [7:0] char_at(logic [4:0] pos, t_line line);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = digit_char(line.digit[0]);
            5'd1:    ch = digit_char(line.digit[1]);
            5'd2:    ch = digit_char(line.digit[2]);
            5'd3:    ch = digit_char(line.digit[3]);
            5'd4:    ch = CharDash;
            5'd5:    ch = digit_char(line.digit[4]);
            5'd6:    ch = digit_char(line.digit[5]);
            5'd7:    ch = CharDash;
            5'd8:    ch = digit_char(line.digit[6]);
            5'd9:    ch = digit_char(line.digit[7]);
            5'd10:   ch = CharT;
            5'd11:   ch = digit_char(line.digit[8]);
            5'd12:   ch = digit_char(line.digit[9]);
            5'd13:   ch = CharColon;
            5'd14:   ch = digit_char(line.digit[10]);
            5'd15:   ch = digit_char(line.digit[11]);
            5'd16:   ch = CharColon;
            5'd17:   ch = digit_char(line.digit[12]);
            5'd18:   ch = digit_char(line.digit[13]);
            5'd19:   ch = CharZ;
            default: ch = CharZ;
        endcase
        return ch;
    endfunction

    assign w_take       = r_busy && !i_stall;
    assign w_at_last    = r_pos == LastPos;
    assign o_line_ready = !r_busy || (w_take && w_at_last);
    assign w_load       = i_line_valid && o_line_ready;

    assign o_valid         = r_busy;
    assign o_char_position = r_pos;
    assign o_last_char     = w_at_last;
    assign o_range_clamped = r_line.clamped;
    assign o_text_char     = char_at(r_pos, r_line);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (w_take) begin
            if (w_at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_line <= i_line;
        end
    end

    `CHK_IMPL(a_pos_range, r_busy, r_pos <= LastPos, "character position past the end")
    `CHK_NEXT(a_wrap_load, w_take && w_at_last && i_line_valid, r_busy && r_pos == '0,
              "next line not started right after the last character")

endmodule

// ===== rtl/core/unix_seconds_to_iso8601_text_core.sv =====
// Each item passes the input register, the queue and the converter sequence before its first character is offered.
// The output stage sends one character per cycle while i_stall is low, and so sets the item rate;
// the converter sequence runs on the next item while the current line is sent.
// A four-entry queue lets the input side keep taking items while the output is stalled.
// Reset is synchronous and active low; it empties the queue and clears all handshakes.
module unix_seconds_to_iso8601_text_core import uts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SecondsW-1:0] i_unix_seconds,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_text_char,
    output logic [4:0]          o_char_position,
    output logic                o_last_char,
    output logic                o_range_clamped
);

    logic  w_full;
    logic  w_push;
    t_item w_push_item;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_line_valid;
    logic  w_line_ready;
    t_line w_line;

    uts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_unix_seconds (i_unix_seconds),
        .o_stall        (o_stall),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    uts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    uts_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (w_line_valid),
        .i_ready (w_line_ready),
        .o_line  (w_line)
    );

    uts_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_valid    (w_line_valid),
        .i_line          (w_line),
        .o_line_ready    (w_line_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_text_char     (o_text_char),
        .o_char_position (o_char_position),
        .o_last_char     (o_last_char),
        .o_range_clamped (o_range_clamped)
    );

endmodule
